// ===== rtl/core/car_pkg.sv =====
// Shared types, codes and the microcode table of the cubic audio resampler core.
// Used by car_seq, car_lane and cubic_audio_resampler_core; depends on nothing.
`default_nettype none

package car_pkg;

   localparam int PC_W = 4;

   localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] PC_COEF_A = 4'd1;
   localparam logic [PC_W-1:0] PC_COEF_B = 4'd2;
   localparam logic [PC_W-1:0] PC_MUL_B  = 4'd3;
   localparam logic [PC_W-1:0] PC_ADD_B  = 4'd4;
   localparam logic [PC_W-1:0] PC_MUL_C  = 4'd5;
   localparam logic [PC_W-1:0] PC_ADD_C  = 4'd6;
   localparam logic [PC_W-1:0] PC_MUL_D  = 4'd7;
   localparam logic [PC_W-1:0] PC_ADD_D  = 4'd8;
   localparam logic [PC_W-1:0] PC_EMIT   = 4'd9;
   localparam logic [PC_W-1:0] PC_DONE   = 4'd10;

   localparam logic [1:0] SEL_B = 2'd0;
   localparam logic [1:0] SEL_C = 2'd1;
   localparam logic [1:0] SEL_D = 2'd2;

   localparam logic [1:0] JUMP_NEXT        = 2'd0;
   localparam logic [1:0] JUMP_ALWAYS      = 2'd1;
   localparam logic [1:0] JUMP_IF_PAST     = 2'd2;
   localparam logic [1:0] JUMP_IF_NOT_PAST = 2'd3;

   localparam logic CSR_PHASE_STEP  = 1'b0;
   localparam logic CSR_STEREO_MODE = 1'b1;

   typedef struct packed {
      logic       load_d;
      logic       coef_a;
      logic       coef_b;
      logic       load_acc;
      logic       mul;
      logic       add;
      logic [1:0] add_sel;
      logic       emit;
      logic       phase_adv;
      logic       phase_wrap;
      logic       push;
   } ctrl_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
      logic phase_past;
      logic adv_past;
   } status_type;

   typedef struct packed {
      logic            wait_in;
      logic            wait_out;
      logic [1:0]      jump;
      logic [PC_W-1:0] target;
      ctrl_type        ops;
   } uword_type;

   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type uw;
      uw = '0;
      unique case (pc)
         PC_IDLE: begin
            uw.wait_in    = 1'b1;
            uw.ops.load_d = 1'b1;
         end
         PC_COEF_A: begin
            uw.ops.coef_a = 1'b1;
         end
         PC_COEF_B: begin
            uw.ops.coef_b   = 1'b1;
            uw.ops.load_acc = 1'b1;
            uw.jump         = JUMP_IF_PAST;
            uw.target       = PC_DONE;
         end
         PC_MUL_B, PC_MUL_C, PC_MUL_D: begin
            uw.ops.mul = 1'b1;
         end
         PC_ADD_B: begin
            uw.ops.add     = 1'b1;
            uw.ops.add_sel = SEL_B;
         end
         PC_ADD_C: begin
            uw.ops.add     = 1'b1;
            uw.ops.add_sel = SEL_C;
         end
         PC_ADD_D: begin
            uw.ops.add     = 1'b1;
            uw.ops.add_sel = SEL_D;
         end
         PC_EMIT: begin
            uw.wait_out      = 1'b1;
            uw.ops.emit      = 1'b1;
            uw.ops.phase_adv = 1'b1;
            uw.ops.load_acc  = 1'b1;
            uw.jump          = JUMP_IF_NOT_PAST;
            uw.target        = PC_MUL_B;
         end
         PC_DONE: begin
            uw.ops.phase_wrap = 1'b1;
            uw.ops.push       = 1'b1;
            uw.jump           = JUMP_ALWAYS;
            uw.target         = PC_IDLE;
         end
         default: begin
            uw.jump   = JUMP_ALWAYS;
            uw.target = PC_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/car_seq.sv =====
// Microcode sequencer: step counter, control word fetch from car_pkg::ucode and branching.
// Depends on car_pkg.
`default_nettype none

module car_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire car_pkg::status_type status,
   output car_pkg::ctrl_type        ctrl,
   output logic                     in_ready
);

   logic [car_pkg::PC_W-1:0] pc_ff;
   logic [car_pkg::PC_W-1:0] pc_in;
   logic [car_pkg::PC_W-1:0] pc_inc;
   car_pkg::uword_type       uw;
   logic                     hold;
   logic                     past;

   assign uw     = car_pkg::ucode(pc_ff);
   assign pc_inc = pc_ff + car_pkg::PC_W'(1);
   assign hold   = (uw.wait_in && !status.in_valid) || (uw.wait_out && !status.out_free);
   assign past   = uw.ops.phase_adv ? status.adv_past : status.phase_past;

   always_comb begin
      pc_in = pc_inc;
      if (hold) begin
         pc_in = pc_ff;
      end else begin
         unique case (uw.jump)
            car_pkg::JUMP_NEXT:        pc_in = pc_inc;
            car_pkg::JUMP_ALWAYS:      pc_in = uw.target;
            car_pkg::JUMP_IF_PAST:     pc_in = past ? uw.target : pc_inc;
            car_pkg::JUMP_IF_NOT_PAST: pc_in = past ? pc_inc : uw.target;
            default:                   pc_in = pc_inc;
         endcase
      end
   end

   assign ctrl     = hold ? '0 : uw.ops;
   assign in_ready = uw.wait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= car_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/car_lane.sv =====
// One channel datapath: sample history, cubic coefficients and the Horner multiply-add.
// Depends on car_pkg for the control word type and operand select codes.
`default_nettype none

module car_lane #(
   parameter int SAMPLE_BITS     = 16,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire car_pkg::ctrl_type             ctrl,
   input  wire logic                          push_en,
   input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
   input  wire logic [PHASE_FRAC_BITS:0]      mu,
   output logic signed [SAMPLE_BITS-1:0]      result
);

   localparam int ACC_W  = SAMPLE_BITS + 5;
   localparam int MU_W   = PHASE_FRAC_BITS + 2;
   localparam int PROD_W = ACC_W + MU_W;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (PHASE_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SMP_MAX = {{6{1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMP_MIN = {{6{1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] hist_ff [3];
   logic signed [SAMPLE_BITS-1:0] d_ff;
   logic signed [ACC_W-1:0]       coef_a_ff;
   logic signed [ACC_W-1:0]       coef_b_ff;
   logic signed [ACC_W-1:0]       coef_c_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [ACC_W-1:0]       acc_in;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W-1:0]      prod_in;
   logic signed [PROD_W-1:0]      rnd_full;
   logic signed [ACC_W-1:0]       rnd_val;
   logic signed [ACC_W-1:0]       addend;
   logic signed [ACC_W-1:0]       a_x;
   logic signed [ACC_W-1:0]       b_x;
   logic signed [ACC_W-1:0]       c_x;
   logic signed [ACC_W-1:0]       d_x;
   logic signed [MU_W-1:0]        mu_s;

   assign a_x  = ACC_W'(hist_ff[2]);
   assign b_x  = ACC_W'(hist_ff[1]);
   assign c_x  = ACC_W'(hist_ff[0]);
   assign d_x  = ACC_W'(d_ff);
   assign mu_s = {1'b0, mu};

   assign prod_in  = PROD_W'(acc_ff) * PROD_W'(mu_s);
   assign rnd_full = (prod_ff + ROUND_HALF) >>> PHASE_FRAC_BITS;
   assign rnd_val  = rnd_full[ACC_W-1:0];

   always_comb begin
      case (ctrl.add_sel)
         car_pkg::SEL_B: addend = coef_b_ff;
         car_pkg::SEL_C: addend = coef_c_ff;
         car_pkg::SEL_D: addend = b_x;
         default:        addend = '0;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load_acc) begin
         acc_in = coef_a_ff;
      end else if (ctrl.add) begin
         acc_in = rnd_val + addend;
      end
   end

   always_comb begin
      if (acc_ff > SMP_MAX) begin
         result = SMP_MAX[SAMPLE_BITS-1:0];
      end else if (acc_ff < SMP_MIN) begin
         result = SMP_MIN[SAMPLE_BITS-1:0];
      end else begin
         result = acc_ff[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         hist_ff[2] <= '0;
      end else if (ctrl.push && push_en) begin
         hist_ff[2] <= hist_ff[1];
         hist_ff[1] <= hist_ff[0];
         hist_ff[0] <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_d) begin
         d_ff <= sample_in;
      end
      if (ctrl.coef_a) begin
         coef_a_ff <= (d_x - c_x) + (b_x - a_x);
         coef_c_ff <= c_x - a_x;
      end
      if (ctrl.coef_b) begin
         coef_b_ff <= (a_x - b_x) - coef_a_ff;
      end
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/cubic_audio_resampler_core.sv =====
// Top level of the cubic interpolation resampler: configuration, phase, result register.
// Depends on car_pkg, car_seq and car_lane.
//
// Usage: input frames arrive on the req_ channel (valid/stall); each accepted transaction
// yields zero or more interpolated frames on the rsp_ channel, the final one of a run
// flagged by rsp_last_of_run. Configuration is written through the csr_ port while idle:
// index 0 is phase_step (Q5.16 input samples per output), index 1 is stereo_mode.
// Each input runs a fixed microcode program: acceptance, the coefficient steps, then
// per output three multiply/round-add steps through the single multiplier of each
// channel and an emit step, and last a step that advances the history.
// req_stall is low only while the sequencer waits for a new input.
// Results sit in an output register; while it holds a result and rsp_stall is high
// the emit step waits until the register drains, and nothing else advances meanwhile.
// Reset clears the histories and phase, sets phase_step to 1.0 and selects mono.
`default_nettype none

module cubic_audio_resampler_core #(
   parameter int SAMPLE_BITS     = 16,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]   req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0]   req_right_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]        rsp_right_out,
   output logic                                 rsp_last_of_run,
   input  wire logic                            csr_write_en,
   input  wire logic                            csr_index,
   input  wire logic [PHASE_FRAC_BITS+4:0]      csr_wdata
);

   localparam int PH_W   = PHASE_FRAC_BITS + 6;
   localparam int STEP_W = PHASE_FRAC_BITS + 5;
   localparam logic [PH_W-1:0]   PHASE_ONE  = PH_W'(1) << PHASE_FRAC_BITS;
   localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1) << (PHASE_FRAC_BITS - 4);
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << PHASE_FRAC_BITS;

   car_pkg::ctrl_type   ctrl;
   car_pkg::status_type status;
   logic                in_ready;

   logic [STEP_W-1:0]   step_ff;
   logic                stereo_ff;
   logic [STEP_W-1:0]   step_eff;
   logic [PH_W-1:0]     phase_ff;
   logic [PH_W-1:0]     phase_in;
   logic [PH_W-1:0]     phase_sum;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;
   logic                last_ff;
   logic signed [SAMPLE_BITS-1:0] left_res;
   logic signed [SAMPLE_BITS-1:0] right_res;
   logic                out_free;

   assign step_eff  = (step_ff < STEP_MIN) ? STEP_MIN : step_ff;
   assign phase_sum = phase_ff + PH_W'(step_eff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign status.in_valid   = req_valid;
   assign status.out_free   = out_free;
   assign status.phase_past = phase_ff > PHASE_ONE;
   assign status.adv_past   = phase_sum > PHASE_ONE;

   car_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .ctrl     (ctrl),
      .in_ready (in_ready)
   );

   car_lane #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .push_en   (1'b1),
      .sample_in (req_left_sample),
      .mu        (phase_ff[PHASE_FRAC_BITS:0]),
      .result    (left_res)
   );

   car_lane #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .push_en   (stereo_ff),
      .sample_in (req_right_sample),
      .mu        (phase_ff[PHASE_FRAC_BITS:0]),
      .result    (right_res)
   );

   assign req_stall = !in_ready;

   always_comb begin
      phase_in = phase_ff;
      if (ctrl.phase_wrap) begin
         phase_in = phase_ff - PHASE_ONE;
      end else if (ctrl.phase_adv) begin
         phase_in = phase_sum;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         stereo_ff    <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               car_pkg::CSR_PHASE_STEP:  step_ff   <= csr_wdata;
               car_pkg::CSR_STEREO_MODE: stereo_ff <= csr_wdata[0];
            endcase
         end
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         left_ff  <= left_res;
         right_ff <= stereo_ff ? right_res : left_res;
         last_ff  <= status.adv_past;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_out    = left_ff;
   assign rsp_right_out   = right_ff;
   assign rsp_last_of_run = last_ff;

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (phase_ff <= PHASE_ONE))
      else $error("result emitted with phase beyond one");

   a_wrap_after_pass: assert property (@(posedge clock) disable iff (reset)
      ctrl.phase_wrap |-> (phase_ff > PHASE_ONE))
      else $error("phase reduced before it passed one");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> out_free)
      else $error("pending result overwritten");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction accepted while busy");

endmodule

`default_nettype wire

// ===== sim/cubic_audio_resampler_core_test.sv =====
// Self-checking testbench for cubic_audio_resampler_core: drives input frames, predicts
// every interpolated output frame and compares each one as it is accepted.
// Depends on car_pkg and the resampler core RTL.
`timescale 1ns / 100ps

module cubic_audio_resampler_core_test;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int STEP_BITS = FRAC_BITS + 5;
   localparam longint PHASE_ONE = longint'(1) << FRAC_BITS;
   localparam longint STEP_FLOOR = PHASE_ONE >> 4;
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam int MAX_FRAMES = 17;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic last;
   } out_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_BITS-1:0] req_left_sample = '0;
   logic signed [SAMPLE_BITS-1:0] req_right_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_left_out;
   logic signed [SAMPLE_BITS-1:0] rsp_right_out;
   logic rsp_last_of_run;
   logic csr_write_en = 1'b0;
   logic csr_index = car_pkg::CSR_PHASE_STEP;
   logic [STEP_BITS-1:0] csr_wdata = '0;

   out_frame_type expected_frames[$];
   int error_count = 0;
   int random_frame_count = 0;
   bit idling_on = 1'b0;

   logic signed [SAMPLE_BITS-1:0] left_hist[3];
   logic signed [SAMPLE_BITS-1:0] right_hist[3];
   logic [FRAC_BITS+5:0] phase_acc = '0;
   logic [STEP_BITS-1:0] step_cfg = STEP_BITS'(PHASE_ONE);
   logic stereo_cfg = 1'b0;

   cubic_audio_resampler_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_left_sample(req_left_sample),
      .req_right_sample(req_right_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint round_q16(input longint x);
      return (x + (PHASE_ONE >>> 1)) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] interpolate(
      input logic signed [SAMPLE_BITS-1:0] oldest,
      input logic signed [SAMPLE_BITS-1:0] middle,
      input logic signed [SAMPLE_BITS-1:0] newest,
      input logic signed [SAMPLE_BITS-1:0] incoming,
      input longint mu);
      longint a, b, c, d, coef_a, coef_b, coef_c, acc;
      a = oldest;
      b = middle;
      c = newest;
      d = incoming;
      coef_a = d - c - a + b;
      coef_b = a - b - coef_a;
      coef_c = c - a;
      acc = round_q16(coef_a * mu) + coef_b;
      acc = round_q16(acc * mu) + coef_c;
      acc = round_q16(acc * mu) + b;
      if (acc > SAMPLE_MAX) begin
         acc = SAMPLE_MAX;
      end else if (acc < SAMPLE_MIN) begin
         acc = SAMPLE_MIN;
      end
      return acc[SAMPLE_BITS-1:0];
   endfunction

   task automatic predict_output_frames(input logic signed [SAMPLE_BITS-1:0] left_in,
                                        input logic signed [SAMPLE_BITS-1:0] right_in);
      logic signed [SAMPLE_BITS-1:0] lh[3];
      logic signed [SAMPLE_BITS-1:0] rh[3];
      longint step;
      int count;
      out_frame_type frame;
      step = (longint'(step_cfg) < STEP_FLOOR) ? STEP_FLOOR : longint'(step_cfg);
      lh = left_hist;
      rh = right_hist;
      left_hist[2] = left_hist[1];
      left_hist[1] = left_hist[0];
      left_hist[0] = left_in;
      if (stereo_cfg) begin
         right_hist[2] = right_hist[1];
         right_hist[1] = right_hist[0];
         right_hist[0] = right_in;
      end
      count = 0;
      while (longint'(phase_acc) <= PHASE_ONE && count < MAX_FRAMES) begin
         frame.left = interpolate(lh[2], lh[1], lh[0], left_in, longint'(phase_acc));
         frame.right = stereo_cfg ?
                       interpolate(rh[2], rh[1], rh[0], right_in, longint'(phase_acc)) :
                       frame.left;
         phase_acc = phase_acc + step[FRAC_BITS+5:0];
         count++;
         frame.last = !(longint'(phase_acc) <= PHASE_ONE && count < MAX_FRAMES);
         expected_frames.push_back(frame);
      end
      phase_acc = phase_acc - PHASE_ONE[FRAC_BITS+5:0];
      random_frame_count += count;
   endtask

   task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] left_in,
                             input logic signed [SAMPLE_BITS-1:0] right_in);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 17)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_left_sample <= left_in;
      req_right_sample <= right_in;
      do @(posedge clock); while (req_stall);
      predict_output_frames(left_in, right_in);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [STEP_BITS-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (index == car_pkg::CSR_PHASE_STEP) begin
         step_cfg = value;
      end else begin
         stereo_cfg = value[0];
      end
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX[SAMPLE_BITS-1:0];
         1: return SAMPLE_MIN[SAMPLE_BITS-1:0];
         2, 3: return SAMPLE_BITS'($urandom_range(0, 2000)) - SAMPLE_BITS'(1000);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [STEP_BITS-1:0] random_step();
      case ($urandom_range(0, 11))
         0: return STEP_BITS'($urandom_range(0, 4095));
         1: return STEP_BITS'($urandom_range(1048577, 2097151));
         2: return 21'd4096;
         3: return 21'd1048576;
         4: return 21'd65536;
         default: return STEP_BITS'($urandom_range(4096, 131072));
      endcase
   endfunction

   task automatic test_mono_after_reset();
      send_frame(16'sd32767, 16'sd0);
      send_frame(-16'sd32768, 16'sd12345);
      send_frame(16'sd32767, -16'sd1);
      send_frame(-16'sd32768, 16'sd32767);
      send_frame(16'sd0, -16'sd32768);
      send_frame(16'sd1, 16'sd0);
      settle_block();
   endtask

   task automatic test_stereo_saturation();
      write_csr(car_pkg::CSR_STEREO_MODE, 21'd1);
      write_csr(car_pkg::CSR_PHASE_STEP, 21'd24576);
      send_frame(16'sd32767, -16'sd32768);
      send_frame(-16'sd32768, 16'sd32767);
      send_frame(16'sd32767, -16'sd32768);
      send_frame(-16'sd32768, 16'sd32767);
      send_frame(16'sd0, 16'sd0);
      settle_block();
   endtask

   task automatic test_fine_step();
      write_csr(car_pkg::CSR_PHASE_STEP, 21'd0);
      send_frame(16'sd20000, -16'sd20000);
      send_frame(-16'sd30000, 16'sd30000);
      settle_block();
      write_csr(car_pkg::CSR_PHASE_STEP, 21'd4095);
      send_frame(16'sd32767, 16'sd32767);
      settle_block();
      write_csr(car_pkg::CSR_PHASE_STEP, 21'd4096);
      send_frame(-16'sd32768, -16'sd32768);
      settle_block();
   endtask

   task automatic test_coarse_step();
      write_csr(car_pkg::CSR_STEREO_MODE, 21'd0);
      write_csr(car_pkg::CSR_PHASE_STEP, 21'h1FFFFF);
      repeat (3) send_frame(random_sample(), random_sample());
      settle_block();
      write_csr(car_pkg::CSR_PHASE_STEP, 21'd1048576);
      repeat (3) send_frame(random_sample(), random_sample());
      settle_block();
   endtask

   task automatic test_random_streams();
      int stream;
      stream = 0;
      random_frame_count = 0;
      idling_on = 1'b1;
      while (stream < 9 || random_frame_count < 60) begin
         write_csr(car_pkg::CSR_PHASE_STEP, random_step());
         write_csr(car_pkg::CSR_STEREO_MODE, STEP_BITS'($urandom()));
         repeat (48) send_frame(random_sample(), random_sample());
         settle_block();
         stream++;
      end
   endtask

   task automatic test_without_idling();
      idling_on = 1'b0;
      write_csr(car_pkg::CSR_STEREO_MODE, 21'd1);
      write_csr(car_pkg::CSR_PHASE_STEP, STEP_BITS'($urandom_range(8192, 98304)));
      repeat (40) send_frame(random_sample(), random_sample());
      settle_block();
   endtask

   always begin
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 18)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      out_frame_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("Unexpected output frame: left %0d right %0d last %0d",
                        rsp_left_out, rsp_right_out, rsp_last_of_run);
            end
         end else begin
            wanted = expected_frames.pop_front();
            if (rsp_left_out !== wanted.left || rsp_right_out !== wanted.right ||
                rsp_last_of_run !== wanted.last) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Output frame mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           wanted.left, wanted.right, wanted.last,
                           rsp_left_out, rsp_right_out, rsp_last_of_run);
               end
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 3; i++) begin
         left_hist[i] = '0;
         right_hist[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_mono_after_reset();
      test_stereo_saturation();
      test_fine_step();
      test_coarse_step();
      test_random_streams();
      test_without_idling();
      if (error_count == 0 && expected_frames.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/car_pkg.sv
rtl/core/car_seq.sv
rtl/core/car_lane.sv
rtl/core/cubic_audio_resampler_core.sv
sim/cubic_audio_resampler_core_test.sv
